### hw/rtl/rdsc_pkg.sv
package rdsc_pkg;

  // value width default and radix register format
  localparam int VALUE_WIDTH_DEF = 31;
  localparam int RADIX_W         = 6;
  localparam int CHAR_W          = 7;
  localparam int APB_DATA_W      = 32;
  localparam int APB_ADDR_W      = 3;

  // register map, word index taken from paddr[APB_ADDR_W-1:2]
  localparam logic [APB_ADDR_W-3:0] REG_RADIX = '0;

  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;

  localparam logic [RADIX_W-1:0] DECIMAL_DIGITS = 6'd10;
  localparam logic [CHAR_W-1:0]  CHAR_ZERO      = 7'd48;
  localparam logic [CHAR_W-1:0]  CHAR_A         = 7'd65;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_READ,
    ST_SHOW
  } rdsc_state_t;

  // out-of-range register values fold onto the nearest legal radix
  function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] res;
    res = r;
    if (r < RADIX_MIN) begin
      res = RADIX_MIN;
    end else if (r > RADIX_MAX) begin
      res = RADIX_MAX;
    end
    return res;
  endfunction

  // digit value to ascii, '0'..'9' then 'A'..'Z'
  function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [RADIX_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < DECIMAL_DIGITS) begin
      c = CHAR_ZERO + {1'b0, d};
    end else begin
      c = CHAR_A + {1'b0, d - DECIMAL_DIGITS};
    end
    return c;
  endfunction

endpackage

### hw/rtl/rdsc_divider.sv
module rdsc_divider
  import rdsc_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [VALUE_WIDTH-1:0] dividend,
  input  logic [RADIX_W-1:0]     divisor,
  output logic                   done,
  output logic [VALUE_WIDTH-1:0] quotient,
  output logic [RADIX_W-1:0]     remainder
);

  localparam int CNT_W = $clog2(VALUE_WIDTH);

  logic                   busy_r;
  logic                   done_r;
  logic [CNT_W-1:0]       cnt_r;
  logic [VALUE_WIDTH-1:0] quo_r;
  logic [RADIX_W-1:0]     rem_r;
  logic [RADIX_W-1:0]     div_r;

  logic [RADIX_W:0]       trial;
  logic [RADIX_W:0]       diff;
  logic                   fits;
  logic [VALUE_WIDTH-1:0] quo_nxt;
  logic [RADIX_W-1:0]     rem_nxt;

  // one restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    trial   = {rem_r, quo_r[VALUE_WIDTH-1]};
    diff    = trial - {1'b0, div_r};
    fits    = (trial >= {1'b0, div_r});
    rem_nxt = fits ? diff[RADIX_W-1:0] : trial[RADIX_W-1:0];
    quo_nxt = {quo_r[VALUE_WIDTH-2:0], fits};
  end

  // step counter and done pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == '0);
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(VALUE_WIDTH - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  // quotient shift register, partial remainder and latched divisor
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      div_r <= divisor;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

### hw/rtl/rdsc_digit_buf.sv
module rdsc_digit_buf
  import rdsc_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           we,
  input  logic [$clog2(VALUE_WIDTH)-1:0] waddr,
  input  logic [CHAR_W-1:0]              wdata,
  input  logic [$clog2(VALUE_WIDTH)-1:0] raddr,
  output logic [CHAR_W-1:0]              rdata
);

  logic [CHAR_W-1:0] mem [VALUE_WIDTH];
  logic [CHAR_W-1:0] rdata_r;

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### hw/rtl/radix_digit_string_converter.sv
// Converts a non-negative integer into its digits in the base held in the
// radix register (2 to 36; 0 and 1 act as 2, 37 to 63 act as 36), one ASCII
// character per output transfer, most significant digit first, with out_last
// on the final digit; zero gives the single character '0'. Each digit comes
// from one pass of a shared restoring divider that retires one quotient bit
// per cycle; digits are collected least significant first in a small buffer
// and then read back in reverse, each character first read from the buffer
// and then held on the output until out_ready takes it. One item is worked
// at a time: in_ready is high only while the block is idle. The radix
// register sits at byte address 0 of the APB-style port and reads back as
// written.
module radix_digit_string_converter
  import rdsc_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // input channel
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [VALUE_WIDTH-1:0] in_value,
  // result channel
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [CHAR_W-1:0]      out_digit_char,
  output logic                   out_last,
  // configuration port
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [APB_ADDR_W-1:0]  paddr,
  input  logic [APB_DATA_W-1:0]  pwdata,
  output logic [APB_DATA_W-1:0]  prdata,
  output logic                   pready
);

  localparam int AW = $clog2(VALUE_WIDTH);

  rdsc_state_t        state_r, state_nxt;
  logic [RADIX_W-1:0] radix_r;
  logic [RADIX_W-1:0] radix_eff_r, radix_eff_nxt;
  logic [AW-1:0]      wr_idx_r, wr_idx_nxt;
  logic [AW-1:0]      rd_ptr_r, rd_ptr_nxt;

  logic                   div_start;
  logic [VALUE_WIDTH-1:0] div_dividend;
  logic [RADIX_W-1:0]     div_divisor;
  logic                   div_done;
  logic [VALUE_WIDTH-1:0] div_quo;
  logic [RADIX_W-1:0]     div_rem;

  logic                   buf_we;
  logic [CHAR_W-1:0]      buf_rdata;

  logic                   reg_wr;

  // apb register write and readback
  assign pready = 1'b1;
  assign reg_wr = psel && penable && pwrite && (paddr[APB_ADDR_W-1:2] == REG_RADIX);
  assign prdata = APB_DATA_W'(radix_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= RADIX_RESET;
    end else if (reg_wr) begin
      radix_r <= pwdata[RADIX_W-1:0];
    end
  end

  // sequencer: divide repeatedly, then play the buffer back in reverse
  always_comb begin
    state_nxt     = state_r;
    radix_eff_nxt = radix_eff_r;
    wr_idx_nxt    = wr_idx_r;
    rd_ptr_nxt    = rd_ptr_r;
    div_start     = 1'b0;
    div_dividend  = div_quo;
    div_divisor   = radix_eff_r;
    buf_we        = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          radix_eff_nxt = clamp_radix(radix_r);
          div_start     = 1'b1;
          div_dividend  = in_value;
          div_divisor   = clamp_radix(radix_r);
          wr_idx_nxt    = '0;
          state_nxt     = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (div_done) begin
          buf_we = 1'b1;
          if (div_quo == '0) begin
            rd_ptr_nxt = wr_idx_r;
            state_nxt  = ST_READ;
          end else begin
            div_start  = 1'b1;
            wr_idx_nxt = wr_idx_r + 1'b1;
          end
        end
      end
      ST_READ: begin
        state_nxt = ST_SHOW;
      end
      ST_SHOW: begin
        if (out_ready) begin
          if (rd_ptr_r == '0) begin
            state_nxt = ST_IDLE;
          end else begin
            rd_ptr_nxt = rd_ptr_r - 1'b1;
            state_nxt  = ST_READ;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    radix_eff_r <= radix_eff_nxt;
    wr_idx_r    <= wr_idx_nxt;
    rd_ptr_r    <= rd_ptr_nxt;
  end

  // handshakes
  assign in_ready       = (state_r == ST_IDLE);
  assign out_valid      = (state_r == ST_SHOW);
  assign out_digit_char = buf_rdata;
  assign out_last       = (rd_ptr_r == '0);

  rdsc_divider #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_divider (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  rdsc_digit_buf #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_digit_buf (
    .clk   (clk),
    .we    (buf_we),
    .waddr (wr_idx_r),
    .wdata (digit_to_ascii(div_rem)),
    .raddr (rd_ptr_r),
    .rdata (buf_rdata)
  );

endmodule

### hw/rtl/rdsc_checker.sv
module rdsc_checker
  import rdsc_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [CHAR_W-1:0] out_digit_char,
  input logic              out_last
);

  // one item at a time: no input taken while a character is on offer
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input ready while output valid");

  // after an input transfer the block is busy
  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input ready right after a transfer");

  // the final character ends the item and frees the input side
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_last) |=> (!out_valid && in_ready))
    else $error("item not finished after last transfer");

  // only digit and capital letter codes appear
  a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_digit_char >= 7'd48 && out_digit_char <= 7'd57) ||
                   (out_digit_char >= 7'd65 && out_digit_char <= 7'd90)))
    else $error("character outside digit set");

  // a stalled character holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_digit_char) && $stable(out_last)))
    else $error("stalled output changed");

endmodule

bind radix_digit_string_converter rdsc_checker u_rdsc_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_digit_char (out_digit_char),
  .out_last       (out_last)
);

### tb/radix_digit_string_converter_tb.sv
module radix_digit_string_converter_tb;
  import rdsc_pkg::*;

  localparam int VW = VALUE_WIDTH_DEF;

  // one expected character on the result channel
  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } digit_t;

  // directed stimulus row: radix setting, value, and the digit string when obvious
  typedef struct {
    logic [RADIX_W-1:0] radix;
    logic [VW-1:0]      value;
    string              digits;
  } dir_row_t;

  localparam int DIR_ROWS = 22;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic [VW-1:0]         in_value;
  logic                  out_valid;
  logic                  out_ready;
  logic [CHAR_W-1:0]     out_digit_char;
  logic                  out_last;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  digit_t             pending_digits[$];
  logic [RADIX_W-1:0] radix_shadow;
  int                 mismatch_count;
  bit                 tx_idle_en;
  bit                 rx_idle_en;
  int                 rx_stall_left;
  dir_row_t           dir_tab [DIR_ROWS];

  radix_digit_string_converter #(
    .VALUE_WIDTH(VW)
  ) DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_digit_char(out_digit_char),
    .out_last      (out_last),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // run limit
  initial begin
    #50_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // expected digit string of a value in the given radix setting, msd first
  function automatic void predict_digits(input logic [VW-1:0] v,
                                         input logic [RADIX_W-1:0] reg_radix);
    longint unsigned   rem_val;
    longint unsigned   base;
    logic [RADIX_W-1:0] digs [VW+1];
    logic [RADIX_W-1:0] d;
    digit_t            item;
    int                n;
    rem_val = longint'(v);
    base = longint'(reg_radix);
    if (base < longint'(RADIX_MIN)) base = longint'(RADIX_MIN);
    if (base > longint'(RADIX_MAX)) base = longint'(RADIX_MAX);
    n = 0;
    do begin
      digs[n] = RADIX_W'(rem_val % base);
      rem_val = rem_val / base;
      n++;
    end while (rem_val != 0 && n < VW + 1);
    for (int k = 0; k < n; k++) begin
      d = digs[n-1-k];
      if (d < DECIMAL_DIGITS) item.ch = CHAR_ZERO + CHAR_W'(d);
      else item.ch = CHAR_A + CHAR_W'(d - DECIMAL_DIGITS);
      item.last = (k == n - 1);
      pending_digits.push_back(item);
    end
  endfunction

  // expected digits typed in as a string
  function automatic void queue_string(input string s);
    digit_t item;
    for (int i = 0; i < s.len(); i++) begin
      item.ch = CHAR_W'(s[i]);
      item.last = (i == s.len() - 1);
      pending_digits.push_back(item);
    end
  endfunction

  // random value, mostly of random bit length so every magnitude shows up
  function automatic logic [VW-1:0] rand_value();
    logic [VW-1:0] v;
    int            len;
    case ($urandom_range(0, 9))
      0: v = '0;
      1: v = '1;
      2: v = VW'($urandom_range(0, 35));
      default: begin
        len = $urandom_range(1, VW);
        v = VW'($urandom);
        v = v & VW'((64'd1 << len) - 1);
      end
    endcase
    return v;
  endfunction

  // one input transfer, then an optional gap
  task automatic send_value(input logic [VW-1:0] v);
    int gap;
    @(negedge clk);
    in_valid <= 1'b1;
    in_value <= v;
    do @(posedge clk); while (!in_ready);
    predict_digits(v, radix_shadow);
    @(negedge clk);
    in_valid <= 1'b0;
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 12);
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // like send_value but with typed expectation and no gap afterwards
  task automatic send_known(input logic [VW-1:0] v, input string s);
    @(negedge clk);
    in_valid <= 1'b1;
    in_value <= v;
    do @(posedge clk); while (!in_ready);
    queue_string(s);
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // wait until every expected digit has arrived and the block is idle again
  task automatic wait_idle();
    while (pending_digits.size() != 0 || !in_ready) @(posedge clk);
  endtask

  // register write followed by a read back
  task automatic write_radix(input logic [RADIX_W-1:0] r);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_RADIX, 2'b00};
    pwdata  <= APB_DATA_W'(r);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    radix_shadow = r;
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[RADIX_W-1:0] !== r) begin
      $display("%0t: radix read back expected %0d got %0d", $time, r,
               prdata[RADIX_W-1:0]);
      mismatch_count++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // result channel backpressure in bursts
  always @(negedge clk) begin
    if (!rx_idle_en) begin
      out_ready <= 1'b1;
      rx_stall_left <= 0;
    end else if (rx_stall_left > 0) begin
      out_ready <= 1'b0;
      rx_stall_left <= rx_stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_ready <= 1'b0;
      rx_stall_left <= $urandom_range(0, 11);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // check each result transfer against the oldest expectation
  always @(posedge clk) begin
    digit_t exp_d;
    if (rst_n && out_valid && out_ready) begin
      if (pending_digits.size() == 0) begin
        $display("%0t: unexpected transfer, expected none got char %0d last %0b",
                 $time, out_digit_char, out_last);
        mismatch_count++;
      end else begin
        exp_d = pending_digits.pop_front();
        if (out_digit_char !== exp_d.ch) begin
          $display("%0t: digit_char expected %0d got %0d", $time, exp_d.ch,
                   out_digit_char);
          mismatch_count++;
        end
        if (out_last !== exp_d.last) begin
          $display("%0t: last expected %0b got %0b", $time, exp_d.last, out_last);
          mismatch_count++;
        end
      end
    end
  end

  // stimulus
  initial begin
    logic [RADIX_W-1:0] phase_radix;
    mismatch_count = 0;
    radix_shadow   = RADIX_RESET;
    tx_idle_en     = 1'b0;
    rx_idle_en     = 1'b0;
    rx_stall_left  = 0;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_value  = '0;
    out_ready = 1'b1;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;

    // radix extremes, folded settings, zero, longest digit strings
    dir_tab = '{
      '{6'd10, 31'd0,          "0"},
      '{6'd10, 31'd2147483647, "2147483647"},
      '{6'd10, 31'd9,          "9"},
      '{6'd10, 31'd10,         "10"},
      '{6'd2,  31'd0,          "0"},
      '{6'd2,  31'd2147483647, ""},
      '{6'd2,  31'd1073741824, ""},
      '{6'd16, 31'd2147483647, "7FFFFFFF"},
      '{6'd16, 31'd715827882,  "2AAAAAAA"},
      '{6'd16, 31'd1431655765, "55555555"},
      '{6'd36, 31'd35,         "Z"},
      '{6'd36, 31'd36,         "10"},
      '{6'd36, 31'd2147483647, ""},
      '{6'd0,  31'd5,          "101"},
      '{6'd1,  31'd0,          "0"},
      '{6'd1,  31'd6,          "110"},
      '{6'd37, 31'd35,         "Z"},
      '{6'd63, 31'd71,         "1Z"},
      '{6'd3,  31'd2147483647, ""},
      '{6'd7,  31'd123456789,  ""},
      '{6'd35, 31'd34,         "Y"},
      '{6'd8,  31'd8,          "10"}
    };

    // reset
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    // directed part, the first row runs on the reset radix
    for (int i = 0; i < DIR_ROWS; i++) begin
      if (dir_tab[i].radix != radix_shadow) begin
        wait_idle();
        write_radix(dir_tab[i].radix);
      end
      if (dir_tab[i].digits.len() != 0) send_known(dir_tab[i].value, dir_tab[i].digits);
      else send_value(dir_tab[i].value);
    end

    // random part: one radix setting per phase, drained between phases
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: phase_radix = 6'd0;
        1: phase_radix = 6'd63;
        2: phase_radix = RADIX_W'($urandom_range(2, 36));
        3: phase_radix = 6'd36;
        4: phase_radix = 6'd1;
        5: phase_radix = RADIX_W'($urandom_range(0, 63));
        6: phase_radix = 6'd37;
        default: phase_radix = RADIX_W'($urandom_range(2, 36));
      endcase
      wait_idle();
      write_radix(phase_radix);
      tx_idle_en = (ph != 3 && ph != 7);
      rx_idle_en = (ph != 3 && ph != 7);
      for (int n = 0; n < 40; n++) send_value(rand_value());
    end

    // drain and watch for stray transfers
    wait_idle();
    repeat (40) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/rdsc_pkg.sv
hw/rtl/rdsc_divider.sv
hw/rtl/rdsc_digit_buf.sv
hw/rtl/radix_digit_string_converter.sv
hw/rtl/rdsc_checker.sv
tb/radix_digit_string_converter_tb.sv
